// ===== design/met_pkg.sv =====
// ----------------------------------------------------------------------------
// met_pkg
// shared types and constants of the equal time stamp counter
// ----------------------------------------------------------------------------
package met_pkg;

	// slot store geometry: one slot per hour and minute of the day
	localparam int SLOT_HOURS   = 24;
	localparam int SLOT_MINUTES = 60;
	localparam int SLOT_DEPTH   = SLOT_HOURS * SLOT_MINUTES;
	localparam int SLOT_AW      = $clog2(SLOT_DEPTH);

	// field widths
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int CNT_W    = 10;
	localparam int IN_DW    = 16;
	localparam int OUT_DW   = 16;

	// batch epoch tag kept beside each count, tag zero marks a cleared slot
	localparam int EPOCH_W = 8;
	localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

	localparam int COUNT_LIMIT_DEF = 1023;

	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [CNT_W-1:0]   cnt;
	} slot_word_t;

	localparam int WORD_W = $bits(slot_word_t);

	// status of the clearing sequencer towards the pipeline
	typedef struct packed {
		logic               busy;
		logic               due;
		logic [SLOT_AW-1:0] addr;
		logic [EPOCH_W-1:0] epoch;
	} sweep_t;

endpackage

// ===== design/met_count_ram.sv =====
// ----------------------------------------------------------------------------
// met_count_ram
// single write port, single read port slot store with registered read data
// ----------------------------------------------------------------------------
module met_count_ram #(
	parameter int DEPTH = 1440,
	parameter int WIDTH = 18,
	parameter int AW    = 11
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read before write on a shared address
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/met_clear_seq.sv =====
// ----------------------------------------------------------------------------
// met_clear_seq
// batch epoch counter and slot store clearing sweep
// ----------------------------------------------------------------------------
module met_clear_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            batch_done,
	output met_pkg::sweep_t sweep
);
	import met_pkg::*;

	logic               busy_q;
	logic [SLOT_AW-1:0] addr_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic               sweep_end;

	assign sweep_end = busy_q && (addr_q == SLOT_AW'(SLOT_DEPTH - 1));

	// sweep after reset and whenever the epoch tags run out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			addr_q  <= '0;
			epoch_q <= EPOCH_FIRST;
		end else if (busy_q) begin
			addr_q <= addr_q + SLOT_AW'(1);
			if (sweep_end) begin
				busy_q  <= 1'b0;
				epoch_q <= EPOCH_FIRST;
			end
		end else if (batch_done) begin
			if (epoch_q == EPOCH_LAST) begin
				busy_q <= 1'b1;
				addr_q <= '0;
			end else begin
				epoch_q <= epoch_q + EPOCH_W'(1);
			end
		end
	end

	assign sweep.busy  = busy_q;
	assign sweep.due   = (epoch_q == EPOCH_LAST);
	assign sweep.addr  = addr_q;
	assign sweep.epoch = epoch_q;

	// the live epoch never takes the cleared tag
	a_epoch_live: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != EPOCH_CLEAR)
		else $error("epoch equals cleared tag");

	// sweep address stays inside the store
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (addr_q < SLOT_AW'(SLOT_DEPTH)))
		else $error("sweep address out of range");

	// sweep ends after the final slot and restarts the epochs
	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_end |=> (!busy_q && epoch_q == EPOCH_FIRST))
		else $error("sweep did not end");

endmodule

// ===== design/max_equal_time_count_unit.sv =====
// ----------------------------------------------------------------------------
// max_equal_time_count_unit
// counts time stamps per hour and minute, gives the largest count on last
// ----------------------------------------------------------------------------
//  channel  dir  fields (lowest bit up)
//  s_*      in   tdata: hour[4:0] minute[10:5], tlast: last of batch
//  m_*      out  tdata: max_count[9:0], one transfer per batch
//
//  one stamp per cycle unless held as below; two stages: slot read, then
//  count update and write back through the one write port, with the last
//  write forwarded; the input is held while the slot store is cleared, once
//  after reset before s_tready rises and again after every 255th batch
//  a result waiting in the output register holds the pipeline only when
//  the next last stamp reaches the update stage
// ----------------------------------------------------------------------------
module max_equal_time_count_unit #(
	parameter int COUNT_LIMIT = met_pkg::COUNT_LIMIT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [met_pkg::IN_DW-1:0]  s_tdata,   // hour[4:0], minute[10:5]
	input  logic                       s_tlast,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [met_pkg::OUT_DW-1:0] m_tdata    // max_count[9:0]
);
	import met_pkg::*;

	localparam int CAP_INT = (COUNT_LIMIT > (2 ** CNT_W - 1)) ? (2 ** CNT_W - 1) :
		((COUNT_LIMIT < 1) ? 1 : COUNT_LIMIT);
	localparam logic [CNT_W-1:0] CAP = CNT_W'(CAP_INT);

	sweep_t             sweep;
	logic               in_xfer;
	logic [HOUR_W-1:0]   in_hour;
	logic [MINUTE_W-1:0] in_minute;
	logic               in_range;
	logic [SLOT_AW-1:0] in_addr;

	logic               vld_s1;
	logic               last_s1;
	logic               range_s1;
	logic [SLOT_AW-1:0] addr_s1;
	slot_word_t         rdata;
	slot_word_t         word_s1;
	logic [CNT_W-1:0]   new_cnt;
	logic [CNT_W-1:0]   max_next;
	logic               stall;
	logic               adv;
	logic               upd_we;
	logic               batch_done;

	logic               wb_vld_q;
	logic [SLOT_AW-1:0] wb_addr_q;
	slot_word_t         wb_word_q;
	logic [CNT_W-1:0]   max_q;
	logic               out_vld_q;
	logic [CNT_W-1:0]   out_cnt_q;

	logic               mem_we;
	logic [SLOT_AW-1:0] mem_waddr;
	slot_word_t         mem_wdata;

	// input decode and slot index
	assign in_hour   = s_tdata[HOUR_W-1:0];
	assign in_minute = s_tdata[HOUR_W+MINUTE_W-1:HOUR_W];
	assign in_range  = (in_hour < HOUR_W'(SLOT_HOURS)) && (in_minute < MINUTE_W'(SLOT_MINUTES));
	assign in_addr   = SLOT_AW'(in_hour) * SLOT_AW'(SLOT_MINUTES) + SLOT_AW'(in_minute);

	// hold only a last stamp that meets a full output register
	assign stall      = vld_s1 && last_s1 && out_vld_q && !m_tready;
	assign adv        = vld_s1 && !stall;
	assign upd_we     = adv && range_s1;
	assign batch_done = adv && last_s1;
	assign s_tready   = !sweep.busy && !stall && !(vld_s1 && last_s1 && sweep.due);
	assign in_xfer    = s_tvalid && s_tready;

	// stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_xfer) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			last_s1  <= s_tlast;
			range_s1 <= in_range;
			addr_s1  <= in_addr;
		end
	end

	// forward the previous write, then update the count
	always_comb begin
		word_s1 = (wb_vld_q && wb_addr_q == addr_s1) ? wb_word_q : rdata;
		if (word_s1.tag != sweep.epoch) begin
			new_cnt = CNT_W'(1);
		end else if (word_s1.cnt < CAP) begin
			new_cnt = word_s1.cnt + CNT_W'(1);
		end else begin
			new_cnt = word_s1.cnt;
		end
		max_next = (range_s1 && new_cnt > max_q) ? new_cnt : max_q;
	end

	// write port shared by the sweep and the update stage
	always_comb begin
		if (sweep.busy) begin
			mem_we          = 1'b1;
			mem_waddr       = sweep.addr;
			mem_wdata.tag   = EPOCH_CLEAR;
			mem_wdata.cnt   = '0;
		end else begin
			mem_we          = upd_we;
			mem_waddr       = addr_s1;
			mem_wdata.tag   = sweep.epoch;
			mem_wdata.cnt   = new_cnt;
		end
	end

	met_count_ram #(
		.DEPTH (SLOT_DEPTH),
		.WIDTH (WORD_W),
		.AW    (SLOT_AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (in_xfer),
		.raddr (in_addr),
		.rdata (rdata)
	);

	met_clear_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.batch_done (batch_done),
		.sweep      (sweep)
	);

	// last write tracking and running maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_vld_q <= 1'b0;
			max_q    <= '0;
		end else begin
			if (sweep.busy) begin
				wb_vld_q <= 1'b0;
			end else if (upd_we) begin
				wb_vld_q <= 1'b1;
			end
			if (batch_done) begin
				max_q <= '0;
			end else if (adv) begin
				max_q <= max_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_we) begin
			wb_addr_q <= addr_s1;
			wb_word_q <= mem_wdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (batch_done) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (batch_done) begin
			out_cnt_q <= max_next;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_DW'(out_cnt_q);

	// no stamp sits in the update stage while the store is swept
	a_no_upd_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweep.busy |-> !vld_s1)
		else $error("update stage busy during sweep");

	// running maximum restarts after every batch
	a_max_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		batch_done |=> (max_q == '0))
		else $error("running maximum not cleared");

	// a stall is only caused by a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> (m_tvalid && !s_tready))
		else $error("stall without waiting result");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the equal time stamp counter: batches of stamps
// go in, each batch's largest count of equal hour and minute values is
// predicted on the fly and compared with every m_* transfer
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import met_pkg::*;

	// count ceiling: the parameter, bounded by the field width
	localparam int FIELD_TOP = (1 << CNT_W) - 1;
	localparam int SAT_CAP   = (COUNT_LIMIT_DEF > FIELD_TOP) ? FIELD_TOP :
	                           (COUNT_LIMIT_DEF < 1) ? 1 : COUNT_LIMIT_DEF;

	typedef struct packed {
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic                last;
	} stamp_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_DW-1:0]  s_tdata  = '0;   // hour[4:0], minute[10:5]
	logic              s_tlast  = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_DW-1:0] m_tdata;         // max_count[9:0]

	stamp_t              stamp_q[$];
	logic [CNT_W-1:0]    peak_q[$];
	stamp_t              next_stamp;
	stamp_t              seen_stamp;
	logic [CNT_W-1:0]    want_peak;
	logic [CNT_W-1:0]    slot_tally[SLOT_DEPTH];
	bit                  slot_live[SLOT_DEPTH];
	logic [CNT_W-1:0]    batch_peak = '0;
	int                  n_err      = 0;
	int                  cyc        = 0;
	bit                  calm;

	max_equal_time_count_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// cycle count, with a window in which neither side ever pauses
	always @(posedge clk) begin
		cyc <= cyc + 1;
	end
	assign calm = (cyc >= 2500) && (cyc < 3500);

	function automatic bit take_break();
		return !calm && ($urandom_range(0, 99) < 8);
	endfunction

	// predicted effect of one accepted stamp
	task automatic tally_stamp(input stamp_t st);
		int slot;
		slot = int'(st.hour) * SLOT_MINUTES + int'(st.minute);
		if (st.hour < SLOT_HOURS && st.minute < SLOT_MINUTES) begin
			if (slot_live[slot]) begin
				if (slot_tally[slot] < SAT_CAP)
					slot_tally[slot] = slot_tally[slot] + 1'b1;
			end else begin
				slot_tally[slot] = CNT_W'(1);
				slot_live[slot]  = 1'b1;
			end
			if (slot_tally[slot] > batch_peak)
				batch_peak = slot_tally[slot];
		end
		// batch end: one result, then a fresh store
		if (st.last) begin
			peak_q.push_back(batch_peak);
			slot_live  = '{default: 1'b0};
			batch_peak = '0;
		end
	endtask

	task automatic push_stamp(input int hr, input int mn, input bit lst);
		stamp_t st;
		st.hour   = HOUR_W'(hr);
		st.minute = MINUTE_W'(mn);
		st.last   = lst;
		stamp_q.push_back(st);
	endtask

	// stamp driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (stamp_q.size() != 0 && !take_break()) begin
				next_stamp = stamp_q.pop_front();
				s_tvalid   <= 1'b1;
				s_tdata    <= {{(IN_DW - HOUR_W - MINUTE_W){1'b0}},
				               next_stamp.minute, next_stamp.hour};
				s_tlast    <= next_stamp.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result sink back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= !take_break();
	end

	// monitor: predict on each stamp transfer, check each result transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				seen_stamp.hour   = s_tdata[HOUR_W-1:0];
				seen_stamp.minute = s_tdata[HOUR_W +: MINUTE_W];
				seen_stamp.last   = s_tlast;
				tally_stamp(seen_stamp);
			end
			if (m_tvalid && m_tready) begin
				if (peak_q.size() == 0) begin
					n_err++;
					$display("%0t: unexpected result, expected none, actual %0d",
					         $time, m_tdata[CNT_W-1:0]);
				end else begin
					want_peak = peak_q.pop_front();
					if (m_tdata[CNT_W-1:0] !== want_peak) begin
						n_err++;
						$display("%0t: max_count mismatch, expected %0d, actual %0d",
						         $time, want_peak, m_tdata[CNT_W-1:0]);
					end
				end
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int counted;
		int n_batch;
		int blen;
		int roll;
		int hr;
		int mn;
		int pool_h[3];
		int pool_m[3];
		bit sat_done;

		// directed: single stamp, both ends of the day
		push_stamp(0, 0, 1);
		push_stamp(23, 59, 0);
		push_stamp(23, 59, 0);
		push_stamp(0, 0, 1);
		// same slot again after batch end, count restarts
		push_stamp(23, 59, 1);
		// empty batch, last on an out of range stamp
		push_stamp(31, 63, 1);
		// out of range stamps mixed in are not counted
		push_stamp(12, 30, 0);
		push_stamp(31, 30, 0);
		push_stamp(12, 30, 0);
		push_stamp(12, 60, 0);
		push_stamp(24, 0, 0);
		push_stamp(12, 30, 1);
		// last on an ignored stamp still closes the batch
		push_stamp(5, 5, 0);
		push_stamp(5, 5, 0);
		push_stamp(6, 6, 0);
		push_stamp(16, 32, 0);
		push_stamp(6, 6, 0);
		push_stamp(6, 6, 0);
		push_stamp(7, 63, 1);
		// empty batch of several ignored stamps
		push_stamp(24, 59, 0);
		push_stamp(0, 60, 0);
		push_stamp(31, 0, 1);

		// random batches, many of them short so the periodic sweep is crossed
		counted  = stamp_q.size();
		n_batch  = 7;
		sat_done = 1'b0;
		while (counted < 1350 || n_batch < 270) begin
			for (int p = 0; p < 3; p++) begin
				pool_h[p] = $urandom_range(0, SLOT_HOURS - 1);
				pool_m[p] = $urandom_range(0, SLOT_MINUTES - 1);
			end
			roll = $urandom_range(0, 99);
			if (roll < 90)
				blen = 1;
			else if (roll < 98)
				blen = $urandom_range(2, 4);
			else
				blen = $urandom_range(10, 20);
			for (int k = 0; k < blen; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 85) begin
					hr = pool_h[roll % 3];
					mn = pool_m[roll % 3];
				end else if (roll < 95) begin
					hr = $urandom_range(0, SLOT_HOURS - 1);
					mn = $urandom_range(0, SLOT_MINUTES - 1);
				end else if (roll < 98) begin
					hr = $urandom_range(SLOT_HOURS, 31);
					mn = $urandom_range(0, 63);
				end else begin
					hr = $urandom_range(0, 31);
					mn = $urandom_range(SLOT_MINUTES, 63);
				end
				push_stamp(hr, mn, k == blen - 1);
			end
			n_batch++;
			// one batch long enough to reach the count ceiling
			if (!sat_done && stamp_q.size() > 100) begin
				sat_done = 1'b1;
				for (int k = 0; k < SAT_CAP + 7; k++) begin
					if (k % 100 == 50)
						push_stamp(3, 14, 0);
					push_stamp(7, 42, k == SAT_CAP + 6);
				end
				n_batch++;
			end
			counted = stamp_q.size();
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (stamp_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (peak_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (n_err == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// watchdog
	initial begin
		#1000000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
design/met_pkg.sv
design/met_count_ram.sv
design/met_clear_seq.sv
design/max_equal_time_count_unit.sv
verif/tb.sv
